[src/lsjd_pkg.sv]
// Package for the line-sensor junction detector.
// Holds the shared constants, register indexes and road codes; depends on nothing.
package lsjd_pkg;

    localparam int CHANNELS         = 8;
    localparam int SAMPLE_BITS_DEF  = 12;
    localparam int CFG_W            = 48;
    localparam int CFG_IDX_W        = 3;
    localparam int WINDOW_W         = 4;
    localparam int ROAD_W           = 3;
    localparam int COUNT_W          = 8;
    localparam int SLOTS_PER_REG    = 4;

    localparam logic [CHANNELS-1:0] OUTER_MASK  = 8'h81;
    localparam logic [CHANNELS-1:0] MIDDLE_MASK = 8'h3C;
    localparam logic [1:0]          PAIR_MASK   = 2'b11;

    localparam logic [ROAD_W-1:0] CODE_UPPER    = 3'b100;
    localparam logic [ROAD_W-1:0] CODE_MIDDLE   = 3'b010;
    localparam logic [ROAD_W-1:0] CODE_LOWER    = 3'b001;
    localparam logic [ROAD_W-1:0] ROAD_STRAIGHT = 3'b010;
    localparam logic [ROAD_W-1:0] ROAD_UNKNOWN  = 3'b000;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_LO   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_HI   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_LO    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_HI    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 3'd4;

    localparam logic [CFG_W-1:0]    RST_HIGH_LO = 48'd3230604124206;
    localparam logic [CFG_W-1:0]    RST_HIGH_HI = 48'd3161867874351;
    localparam logic [CFG_W-1:0]    RST_LOW_LO  = 48'd1718389669912;
    localparam logic [CFG_W-1:0]    RST_LOW_HI  = 48'd1649686974489;
    localparam logic [WINDOW_W-1:0] RST_WINDOW  = 4'd4;

    // Road code from the ORed window bits and the deciding frame's bits.
    function automatic logic [ROAD_W-1:0] decide_code(
        input logic [CHANNELS-1:0] acc,
        input logic [CHANNELS-1:0] bits
    );
        logic [ROAD_W-1:0] code;
        code = ROAD_UNKNOWN;
        if (acc[7:6] == PAIR_MASK) code = code | CODE_UPPER;
        if ((bits & MIDDLE_MASK) != '0) code = code | CODE_MIDDLE;
        if (acc[1:0] == PAIR_MASK) code = code | CODE_LOWER;
        return code;
    endfunction

endpackage

[src/line_sensor_junction_detector.sv]
// Line-sensor junction detector: hysteresis comparators, window accumulation, road code.
// Depends on lsjd_pkg for constants, register indexes and the road-code function.
// A word moves from the input register to the result register once the result register is free.
// Throughput: one word per cycle while results are taken; all per-frame work is
// one combinational pass between the input register and the result register.
// Reset (synchronous, i_rst_n low) empties both stages and loads the registers' defaults.
module line_sensor_junction_detector
    import lsjd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write channel.
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data,
    // Input channel: one frame of samples per word.
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [SAMPLE_BITS-1:0] i_sample_0,
    input  logic [SAMPLE_BITS-1:0] i_sample_1,
    input  logic [SAMPLE_BITS-1:0] i_sample_2,
    input  logic [SAMPLE_BITS-1:0] i_sample_3,
    input  logic [SAMPLE_BITS-1:0] i_sample_4,
    input  logic [SAMPLE_BITS-1:0] i_sample_5,
    input  logic [SAMPLE_BITS-1:0] i_sample_6,
    input  logic [SAMPLE_BITS-1:0] i_sample_7,
    // Output channel: one result word per frame.
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [CHANNELS-1:0]    o_line_seen_bits,
    output logic [ROAD_W-1:0]      o_road_kind,
    output logic                   o_decided,
    output logic [COUNT_W-1:0]     o_junction_total
);

    // The 48-bit threshold registers are widened so that four slots always fit;
    // slots beyond bit 47 read as zero.
    localparam int EXT_W = (SLOTS_PER_REG * SAMPLE_BITS > CFG_W) ?
                           SLOTS_PER_REG * SAMPLE_BITS : CFG_W;

    // Configuration registers.
    logic [CFG_W-1:0]    r_high_lo, r_high_hi, r_low_lo, r_low_hi;
    logic [WINDOW_W-1:0] r_window_frames;

    // Frame state carried from one word to the next.
    logic [CHANNELS-1:0] r_held_bits, n_held_bits;
    logic [ROAD_W-1:0]   r_road_now, n_road_now;
    logic [WINDOW_W-1:0] r_window_left, n_window_left;
    logic [CHANNELS-1:0] r_or_acc, n_or_acc;
    logic [COUNT_W-1:0]  r_junctions, n_junctions;
    logic                n_decided;

    // Input register stage.
    logic                   r_in_valid;
    logic [SAMPLE_BITS-1:0] r_samples [CHANNELS];

    // Result register stage.
    logic                r_out_valid;
    logic [CHANNELS-1:0] r_out_bits;
    logic [ROAD_W-1:0]   r_out_road;
    logic                r_out_decided;
    logic [COUNT_W-1:0]  r_out_junctions;

    logic out_free, advance, in_accept;

    // The result register can take a word when it is empty or being emptied.
    // The input register then hands its word over in the same edge, so a new
    // frame can enter every cycle as long as the far side keeps taking results.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_lo       <= RST_HIGH_LO;
            r_high_hi       <= RST_HIGH_HI;
            r_low_lo        <= RST_LOW_LO;
            r_low_hi        <= RST_LOW_HI;
            r_window_frames <= RST_WINDOW;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_HIGH_LO: r_high_lo       <= i_cfg_data;
                REG_HIGH_HI: r_high_hi       <= i_cfg_data;
                REG_LOW_LO:  r_low_lo        <= i_cfg_data;
                REG_LOW_HI:  r_low_hi        <= i_cfg_data;
                REG_WINDOW:  r_window_frames <= i_cfg_data[WINDOW_W-1:0];
                default: ;
            endcase
        end
    end

    // Input stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_samples[0] <= i_sample_0;
            r_samples[1] <= i_sample_1;
            r_samples[2] <= i_sample_2;
            r_samples[3] <= i_sample_3;
            r_samples[4] <= i_sample_4;
            r_samples[5] <= i_sample_5;
            r_samples[6] <= i_sample_6;
            r_samples[7] <= i_sample_7;
        end
    end

    // Hysteresis comparators. The clear test wins, so equal thresholds or a
    // low threshold above the high one still give a defined result.
    always_comb begin
        logic [EXT_W-1:0]       hi_reg, lo_reg;
        logic [SAMPLE_BITS-1:0] hi_thr, lo_thr;
        n_held_bits = r_held_bits;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            if (ch < SLOTS_PER_REG) begin
                hi_reg = EXT_W'(r_high_lo);
                lo_reg = EXT_W'(r_low_lo);
            end else begin
                hi_reg = EXT_W'(r_high_hi);
                lo_reg = EXT_W'(r_low_hi);
            end
            hi_thr = hi_reg[(ch % SLOTS_PER_REG) * SAMPLE_BITS +: SAMPLE_BITS];
            lo_thr = lo_reg[(ch % SLOTS_PER_REG) * SAMPLE_BITS +: SAMPLE_BITS];
            if (r_samples[ch] > hi_thr) begin
                n_held_bits[ch] = 1'b0;
            end else if (r_samples[ch] < lo_thr) begin
                n_held_bits[ch] = 1'b1;
            end
        end
    end

    // Road tracking. While straight, an outer hit opens a window that ORs the
    // frame bits together; its last frame decides the new road code. Away from
    // straight, a frame that shows a middle sensor and no outer sensor goes back to straight.
    // A window length of zero never opens: the hit only ORs into the accumulator.
    always_comb begin
        logic [ROAD_W-1:0] code;
        n_road_now    = r_road_now;
        n_window_left = r_window_left;
        n_or_acc      = r_or_acc;
        n_junctions   = r_junctions;
        n_decided     = 1'b0;
        code          = decide_code(r_or_acc, n_held_bits);
        if (r_road_now == ROAD_STRAIGHT) begin
            if ((n_held_bits & OUTER_MASK) != '0 && r_window_left == '0) begin
                n_window_left = r_window_frames;
                n_or_acc      = r_or_acc | n_held_bits;
            end
            if (n_window_left > WINDOW_W'(1)) begin
                n_or_acc      = n_or_acc | n_held_bits;
                n_window_left = n_window_left - WINDOW_W'(1);
            end else if (n_window_left == WINDOW_W'(1)) begin
                // The accumulator is untouched on a one-frame window's first
                // frame apart from this frame's bits, which hold both pairs too.
                code       = decide_code(n_or_acc, n_held_bits);
                n_road_now = code;
                if (code != ROAD_STRAIGHT && code != ROAD_UNKNOWN) begin
                    n_junctions = r_junctions + COUNT_W'(1);
                end
                n_window_left = '0;
                n_or_acc      = '0;
                n_decided     = 1'b1;
            end
        end else if ((n_held_bits & OUTER_MASK) == '0 &&
                     (n_held_bits & MIDDLE_MASK) != '0) begin
            n_road_now = ROAD_STRAIGHT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_bits   <= '0;
            r_road_now    <= ROAD_STRAIGHT;
            r_window_left <= '0;
            r_or_acc      <= '0;
            r_junctions   <= '0;
        end else if (advance) begin
            r_held_bits   <= n_held_bits;
            r_road_now    <= n_road_now;
            r_window_left <= n_window_left;
            r_or_acc      <= n_or_acc;
            r_junctions   <= n_junctions;
        end
    end

    // Result stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_bits      <= n_held_bits;
            r_out_road      <= n_road_now;
            r_out_decided   <= n_decided;
            r_out_junctions <= n_junctions;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_line_seen_bits = r_out_bits;
    assign o_road_kind      = r_out_road;
    assign o_decided        = r_out_decided;
    assign o_junction_total = r_out_junctions;

endmodule

[src/lsjd_checker.sv]
// Port-level checker for the line-sensor junction detector, bound to the top level.
// Depends on lsjd_pkg for road codes and widths.
module lsjd_checker
    import lsjd_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic [CHANNELS-1:0] o_line_seen_bits,
    input logic [ROAD_W-1:0]   o_road_kind,
    input logic                o_decided,
    input logic [COUNT_W-1:0]  o_junction_total
);

    logic              out_word;
    logic [COUNT_W-1:0] r_last_total;
    logic [ROAD_W-1:0]  r_last_road;

    assign out_word = o_out_valid && !i_out_stall;

    // Last delivered count and road code; reset matches the block's own state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_total <= '0;
            r_last_road  <= ROAD_STRAIGHT;
        end else if (out_word) begin
            r_last_total <= o_junction_total;
            r_last_road  <= o_road_kind;
        end
    end

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_road_kind) &&
            $stable(o_junction_total) && $stable(o_line_seen_bits) && $stable(o_decided))
        else $error("stalled result changed");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_word && o_junction_total != r_last_total |->
            o_junction_total == r_last_total + COUNT_W'(1) && o_decided &&
            o_road_kind != ROAD_STRAIGHT && o_road_kind != ROAD_UNKNOWN)
        else $error("junction count moved without a junction decision");

    a_road_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_word && !o_decided && o_road_kind != r_last_road |->
            o_road_kind == ROAD_STRAIGHT && r_last_road != ROAD_STRAIGHT)
        else $error("road code changed without a decision");

endmodule

bind line_sensor_junction_detector lsjd_checker u_lsjd_checker (.*);
